@@ design/mvc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mvc_pkg;

	localparam int MAX_BALLS = 16;
	localparam int MAX_GRID = 32;
	localparam int BALL_IDX_W = $clog2(MAX_BALLS);
	localparam int BALL_CNT_W = $clog2(MAX_BALLS + 1);
	localparam int GRID_W = $clog2(MAX_GRID + 2);

	localparam int DVD_W = 52;
	localparam int DVS_W = 34;
	localparam int CNT_W = $clog2(DVD_W + 1);

	localparam logic [33:0] SQ_FLOOR = 34'd26844;
	localparam logic [31:0] ENERGY_MAX = 32'hFFFF_FFFF;

	localparam logic [1:0] CFG_BALL_COUNT = 2'd0;
	localparam logic [1:0] CFG_GRID_SIZE = 2'd1;
	localparam logic [1:0] CFG_ISO_LEVEL = 2'd2;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_CLASSIFY = 1'b1;

	typedef struct packed {
		logic req_type;
		logic [3:0] ball_slot;
		logic signed [15:0] ball_px;
		logic signed [15:0] ball_py;
		logic signed [15:0] ball_pz;
		logic [15:0] ball_mass;
		logic [4:0] voxel_x;
		logic [4:0] voxel_y;
		logic [4:0] voxel_z;
	} req_t;

	typedef struct packed {
		logic [7:0] cube_case;
		logic voxel_full;
		logic energy_clipped;
	} rsp_t;

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] pz;
		logic [15:0] mass;
	} ball_t;

	typedef struct packed {
		logic start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	// Corner offsets as {z, y, x} in marching-cubes order.
	function automatic logic [2:0] corner_off(input logic [2:0] k);
		logic [2:0] r;
		case (k)
			3'd0: r = 3'b000;
			3'd1: r = 3'b001;
			3'd2: r = 3'b101;
			3'd3: r = 3'b100;
			3'd4: r = 3'b010;
			3'd5: r = 3'b011;
			3'd6: r = 3'b111;
			default: r = 3'b110;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/mvc_ball_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mvc_ball_cell
	import mvc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load,
	input wire logic shift,
	input wire ball_t load_data,
	input wire ball_t shift_in,
	output ball_t held
);

	ball_t ball_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ball_q <= '0;
		end else if (load) begin
			ball_q <= load_data;
		end else if (shift) begin
			ball_q <= shift_in;
		end
	end

	assign held = ball_q;

endmodule
`default_nettype wire

@@ design/mvc_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mvc_divider
	import mvc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire div_req_t req,
	output div_rsp_t rsp
);

	logic [DVS_W:0] rem_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [DVS_W+1:0] trial;
	logic [DVS_W:0] shifted;

	always_comb begin
		shifted = {rem_q[DVS_W-1:0], dvd_q[DVD_W-1]};
		trial = {1'b0, shifted} - {2'b00, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (run_q) begin
			if (!trial[DVS_W+1]) begin
				rem_q <= trial[DVS_W:0];
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = dvd_q;

endmodule
`default_nettype wire

@@ design/metaball_voxel_classifier.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A load beat writes one ball slot and gives no result. A classify beat
// walks the 8 corners: a border corner goes straight to evaluation, and
// for any other the single bit-serial divider works out grid coordinates
// and every ball term, while the ball ring turns one cell per ball step.
// The result is on result for one cycle with result_valid high and
// cannot be held off; busy is high from an accepted classify beat until then.
module metaball_voxel_classifier
	import mvc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire req_t req,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [30:0] cfg_wdata,
	output logic result_valid,
	output rsp_t result
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CORNER = 3'd1;
	localparam logic [2:0] S_COORD = 3'd2;
	localparam logic [2:0] S_COORD_W = 3'd3;
	localparam logic [2:0] S_BALL = 3'd4;
	localparam logic [2:0] S_SQ = 3'd5;
	localparam logic [2:0] S_DIV_W = 3'd6;
	localparam logic [2:0] S_EVAL = 3'd7;

	logic [2:0] state_q;
	logic [4:0] ball_count_q;
	logic [5:0] grid_size_q;
	logic [30:0] iso_level_q;
	logic [4:0] vx_q, vy_q, vz_q;
	logic [2:0] corner_q;
	logic [1:0] axis_q;
	logic signed [16:0] gw_q [3];
	logic [BALL_CNT_W-1:0] idx_q;
	logic [32:0] acc_q;
	logic sat_q;
	logic [33:0] sq_q;
	logic [7:0] case_q;
	logic clip_q;
	logic result_valid_q;
	rsp_t result_q;

	ball_t held [MAX_BALLS];
	logic ring_shift;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [GRID_W-1:0] geff;
	logic [BALL_CNT_W-1:0] neff;
	logic [2:0] off;
	logic [GRID_W-1:0] cx, cy, cz, csel;
	logic border;
	logic signed [17:0] dsel;
	logic signed [35:0] prod;
	logic [33:0] sq_sum;
	logic [33:0] sq_fl;
	logic [32:0] acc_sum;
	logic [31:0] energy;

	always_comb begin
		if (grid_size_q < 6'd2) begin
			geff = GRID_W'(2);
		end else if (GRID_W'(grid_size_q) > GRID_W'(MAX_GRID)) begin
			geff = GRID_W'(MAX_GRID);
		end else begin
			geff = GRID_W'(grid_size_q);
		end
		if (BALL_CNT_W'(ball_count_q) > BALL_CNT_W'(MAX_BALLS)) begin
			neff = BALL_CNT_W'(MAX_BALLS);
		end else begin
			neff = BALL_CNT_W'(ball_count_q);
		end
		off = corner_off(corner_q);
		cx = GRID_W'(vx_q) + GRID_W'(off[0]);
		cy = GRID_W'(vy_q) + GRID_W'(off[1]);
		cz = GRID_W'(vz_q) + GRID_W'(off[2]);
		border = (cx >= geff) || (cy >= geff) || (cz >= geff) ||
			(cx == '0) || (cy == '0) || (cz == '0);
		case (axis_q)
			2'd0: csel = cx;
			2'd1: csel = cy;
			default: csel = cz;
		endcase
		case (axis_q)
			2'd0: dsel = 18'(held[0].px) - 18'(gw_q[0]);
			2'd1: dsel = 18'(held[0].py) - 18'(gw_q[1]);
			default: dsel = 18'(held[0].pz) - 18'(gw_q[2]);
		endcase
		prod = dsel * dsel;
		sq_sum = sq_q + prod[33:0];
		sq_fl = (sq_sum < SQ_FLOOR) ? SQ_FLOOR : sq_sum;
		acc_sum = acc_q + div_rsp.quotient[32:0];
		energy = sat_q ? ENERGY_MAX : acc_q[31:0];
	end

	always_comb begin
		div_req = '0;
		ring_shift = 1'b0;
		unique case (state_q)
			S_COORD: begin
				div_req.start = 1'b1;
				div_req.dividend = DVD_W'({csel, 15'd0}) + DVD_W'(geff >> 1);
				div_req.divisor = DVS_W'(geff);
			end
			S_SQ: begin
				if (axis_q == 2'd2) begin
					div_req.start = 1'b1;
					div_req.dividend = {held[0].mass, 36'd0};
					div_req.divisor = sq_fl;
				end
			end
			S_BALL: begin
				if (idx_q != BALL_CNT_W'(MAX_BALLS) && !(idx_q < neff && !sat_q)) begin
					ring_shift = 1'b1;
				end
			end
			S_DIV_W: ring_shift = div_rsp.done;
			default: ring_shift = 1'b0;
		endcase
	end

	mvc_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	for (genvar i = 0; i < MAX_BALLS; i++) begin : g_ring
		localparam int NEXT = (i + 1) % MAX_BALLS;
		ball_t load_data;
		assign load_data = '{px: req.ball_px, py: req.ball_py, pz: req.ball_pz,
			mass: req.ball_mass};
		mvc_ball_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.load(start && !busy && req.req_type == REQ_LOAD &&
				req.ball_slot == BALL_IDX_W'(i)),
			.shift(ring_shift),
			.load_data(load_data),
			.shift_in(held[NEXT]),
			.held(held[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ball_count_q <= 5'd4;
			grid_size_q <= 6'd32;
			iso_level_q <= 31'd6553600;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BALL_COUNT: ball_count_q <= cfg_wdata[4:0];
				CFG_GRID_SIZE: grid_size_q <= cfg_wdata[5:0];
				CFG_ISO_LEVEL: iso_level_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			result_valid_q <= 1'b0;
			corner_q <= '0;
			axis_q <= '0;
			idx_q <= '0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start && req.req_type == REQ_CLASSIFY) begin
						corner_q <= '0;
						state_q <= S_CORNER;
					end
				end
				S_CORNER: begin
					axis_q <= '0;
					idx_q <= '0;
					state_q <= border ? S_EVAL : S_COORD;
				end
				S_COORD: state_q <= S_COORD_W;
				S_COORD_W: begin
					if (div_rsp.done) begin
						axis_q <= axis_q + 1'b1;
						state_q <= (axis_q == 2'd2) ? S_BALL : S_COORD;
					end
				end
				S_BALL: begin
					axis_q <= '0;
					if (idx_q == BALL_CNT_W'(MAX_BALLS)) begin
						state_q <= S_EVAL;
					end else if (idx_q < neff && !sat_q) begin
						state_q <= S_SQ;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SQ: begin
					axis_q <= axis_q + 1'b1;
					if (axis_q == 2'd2) begin
						state_q <= S_DIV_W;
					end
				end
				S_DIV_W: begin
					if (div_rsp.done) begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_BALL;
					end
				end
				S_EVAL: begin
					corner_q <= corner_q + 1'b1;
					if (corner_q == 3'd7) begin
						state_q <= S_IDLE;
						result_valid_q <= 1'b1;
					end else begin
						state_q <= S_CORNER;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				vx_q <= req.voxel_x;
				vy_q <= req.voxel_y;
				vz_q <= req.voxel_z;
				case_q <= '0;
				clip_q <= 1'b0;
			end
			S_CORNER: begin
				acc_q <= '0;
				sat_q <= 1'b0;
			end
			S_COORD_W: begin
				if (div_rsp.done) begin
					gw_q[axis_q] <= $signed({1'b0, div_rsp.quotient[15:0]}) - 17'sd16384;
				end
			end
			S_BALL: sq_q <= '0;
			S_SQ: sq_q <= sq_sum;
			S_DIV_W: begin
				if (div_rsp.done) begin
					if (div_rsp.quotient[DVD_W-1:32] != '0 ||
						acc_sum >= {1'b0, ENERGY_MAX}) begin
						sat_q <= 1'b1;
					end else begin
						acc_q <= acc_sum;
					end
				end
			end
			S_EVAL: begin
				case_q[corner_q] <= energy > {1'b0, iso_level_q};
				clip_q <= clip_q | (energy == ENERGY_MAX);
				if (corner_q == 3'd7) begin
					result_q.cube_case <= {energy > {1'b0, iso_level_q}, case_q[6:0]};
					result_q.voxel_full <= (energy > {1'b0, iso_level_q}) &&
						(case_q[6:0] == 7'h7F);
					result_q.energy_clipped <= clip_q | (energy == ENERGY_MAX);
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result = result_q;

	a_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result beat while busy");

	a_full_means_all: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.voxel_full |-> result.cube_case == 8'hFF)
		else $error("voxel_full without all corners inside");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.req_type == REQ_LOAD |=> !busy && !result_valid)
		else $error("load beat caused work or a result");

endmodule
`default_nettype wire
